[sv/dsh_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the diamond-square height map block.
// No dependencies; used by the top level.
package dsh_pkg;

    localparam int MAP_SIDE_MAX_DEF = 129;
    localparam int HEIGHT_BITS_DEF  = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_SIDE   = 2'd0;
    localparam logic [1:0] CFG_START_STEP = 2'd1;
    localparam logic [1:0] CFG_NOISE_AMP  = 2'd2;

    localparam logic [7:0]  MAP_SIDE_RST   = 8'd129;
    localparam logic [7:0]  START_STEP_RST = 8'd32;
    localparam logic [15:0] NOISE_AMP_RST  = 16'd256;

    // pass phases
    localparam logic [1:0] PH_SEED    = 2'd0;
    localparam logic [1:0] PH_DIAMOND = 2'd1;
    localparam logic [1:0] PH_SQUARE  = 2'd2;

    // offset f = 25*r - 10 in Q16
    localparam int          F_SCALE    = 25;
    localparam logic [21:0] F_OFFSET   = 22'd655360;

endpackage

[sv/dsh_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dsh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16641
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/diamond_square_heightmap.sv]
`timescale 1ns / 1ps
// Diamond-square height map generator, top level.
// Depends on dsh_pkg and dsh_ram.

// One request carries one random fraction and yields one result. A seed
// point or a skipped edge point goes through the setup and finish states
// to the result register; a diamond centre or edge point also passes
// through the read and multiply states, since its four neighbours are
// read one per cycle through the single read port of the height store.
// The block takes one request at a time. After reset and after the last
// result of every map, the height store is swept to zero at one entry per
// cycle over all MAP_SIDE_MAX*MAP_SIDE_MAX entries (16641 by default),
// during which no request is accepted; configuration writes are taken at
// any time and are latched when a map starts.
module diamond_square_heightmap #(
    parameter int MAP_SIDE_MAX = dsh_pkg::MAP_SIDE_MAX_DEF,
    parameter int HEIGHT_BITS  = dsh_pkg::HEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_random_fraction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_cell_x,
    output logic [7:0]  o_cell_z,
    output logic signed [23:0] o_height,
    output logic        o_wrote,
    output logic        o_map_done
);

    localparam int DEPTH = MAP_SIDE_MAX * MAP_SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAP_SIDE_MAX);
    localparam int CW    = $clog2(MAP_SIDE_MAX + 256);
    localparam int SW    = CW + 1;
    localparam int HB    = HEIGHT_BITS;
    localparam int SMW   = HB + 2;
    localparam int PW    = 39;
    localparam int QW    = HB + 24;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    localparam logic signed [QW-1:0] H_MAX = {{(QW-HB+1){1'b0}}, {(HB-1){1'b1}}};
    localparam logic signed [QW-1:0] H_MIN = {{(QW-HB+1){1'b1}}, {(HB-1){1'b0}}};
    localparam logic signed [QW-1:0] RND   = QW'(2048);

    logic [2:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_phase;
    logic [CW-1:0] r_wx, r_wz, r_side, r_tx, r_tz;
    logic [7:0]    r_step;
    logic [15:0]   r_noise;
    logic          r_edge, r_skip;
    logic signed [21:0]  r_f16;
    logic [1:0]    r_k;
    logic signed [SMW-1:0] r_sum;
    logic          r_rd_v, r_rd_in;
    logic signed [PW-1:0] r_prod;
    logic [7:0]    r_cfg_side, r_cfg_step;
    logic [15:0]   r_cfg_noise;
    logic          r_ov, r_ow, r_od;
    logic [7:0]    r_ox, r_oz;
    logic [23:0]   r_oh;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_side  <= dsh_pkg::MAP_SIDE_RST;
            r_cfg_step  <= dsh_pkg::START_STEP_RST;
            r_cfg_noise <= dsh_pkg::NOISE_AMP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dsh_pkg::CFG_MAP_SIDE) begin
                r_cfg_side <= i_cfg_wdata[7:0];
            end
            if (i_cfg_index == dsh_pkg::CFG_START_STEP) begin
                r_cfg_step <= i_cfg_wdata[7:0];
            end
            if (i_cfg_index == dsh_pkg::CFG_NOISE_AMP) begin
                r_cfg_noise <= i_cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------- datapath logic
    logic w_in_acc, w_slot;
    logic [CW-1:0] w_half, w_cfg_side;
    logic signed [21:0] w_f16;
    logic signed [SW-1:0] w_nx, w_nz, w_dh;
    logic w_inmap;
    logic [AW-1:0] w_raddr, w_taddr, w_waddr;
    logic [HB-1:0] w_rdata, w_wdata;
    logic w_we;
    logic signed [QW-1:0] w_q, w_r, w_sat;

    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_slot   = !r_ov || !i_out_stall;
    assign w_half   = CW'(r_step >> 1);
    assign w_dh     = SW'(r_step >> 1);
    assign w_f16    = $signed({6'd0, i_random_fraction}) * 22'(dsh_pkg::F_SCALE)
                      - $signed(dsh_pkg::F_OFFSET);

    always_comb begin
        w_cfg_side = CW'(r_cfg_side);
        if (w_cfg_side == '0) begin
            w_cfg_side = CW'(1);
        end else if (w_cfg_side > CW'(MAP_SIDE_MAX)) begin
            w_cfg_side = CW'(MAP_SIDE_MAX);
        end
    end

    // neighbour for read slot r_k
    always_comb begin
        w_nx = $signed({1'b0, r_tx});
        w_nz = $signed({1'b0, r_tz});
        if (r_phase == dsh_pkg::PH_DIAMOND) begin
            w_nx = r_k[0] ? w_nx + w_dh : w_nx - w_dh;
            w_nz = r_k[1] ? w_nz + w_dh : w_nz - w_dh;
        end else if (!r_k[1]) begin
            w_nx = r_k[0] ? w_nx + w_dh : w_nx - w_dh;
        end else begin
            w_nz = r_k[0] ? w_nz + w_dh : w_nz - w_dh;
        end
        w_inmap = !w_nx[SW-1] && !w_nz[SW-1]
                  && (w_nx[CW-1:0] < r_side) && (w_nz[CW-1:0] < r_side);
    end

    assign w_raddr = AW'(w_nz[XW-1:0]) * AW'(MAP_SIDE_MAX) + AW'(w_nx[XW-1:0]);
    assign w_taddr = AW'(r_tz[XW-1:0]) * AW'(MAP_SIDE_MAX) + AW'(r_tx[XW-1:0]);

    // shared round-and-saturate: Q24 value down to Q12
    always_comb begin
        if (r_phase == dsh_pkg::PH_SEED) begin
            w_q = QW'(r_f16) <<< 8;
        end else begin
            w_q = (QW'(r_sum) <<< 10) + QW'(r_prod);
        end
        w_r = (w_q + RND) >>> 12;
        if (w_r > H_MAX) begin
            w_sat = H_MAX;
        end else if (w_r < H_MIN) begin
            w_sat = H_MIN;
        end else begin
            w_sat = w_r;
        end
    end

    assign w_we    = (r_state == S_CLR) || (r_state == S_FIN && w_slot && !r_skip);
    assign w_waddr = (r_state == S_CLR) ? r_clr : w_taddr;
    assign w_wdata = (r_state == S_CLR) ? '0 : w_sat[HB-1:0];

    dsh_ram #(
        .WIDTH(HB),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // walk advance after the finishing write
    logic [1:0]    n_phase;
    logic [CW-1:0] n_wx, n_wz;
    logic [7:0]    n_step;
    logic [15:0]   n_noise;
    logic          n_edge, n_done, w_bl;
    logic [7:0]    w_bl_step;

    always_comb begin
        n_phase = r_phase;
        n_wx    = r_wx;
        n_wz    = r_wz;
        n_step  = r_step;
        n_noise = r_noise;
        n_edge  = r_edge;
        n_done  = 1'b0;
        w_bl    = 1'b0;
        w_bl_step = r_step;
        unique case (r_phase)
            dsh_pkg::PH_DIAMOND: begin
                n_wx = r_wx + CW'(r_step);
                if (n_wx >= r_side) begin
                    n_wx = w_half;
                    n_wz = r_wz + CW'(r_step);
                    if (n_wz >= r_side) begin
                        n_phase = dsh_pkg::PH_SQUARE;
                        n_wx = '0;
                        n_wz = '0;
                        n_edge = 1'b0;
                    end
                end
            end
            dsh_pkg::PH_SQUARE: begin
                n_edge = !r_edge;
                if (r_edge) begin
                    n_wx = r_wx + CW'(r_step);
                    if (n_wx >= r_side) begin
                        n_wx = '0;
                        n_wz = r_wz + CW'(r_step);
                        if (n_wz >= r_side) begin
                            n_step  = r_step >> 1;
                            n_noise = r_noise >> 1;
                            w_bl    = 1'b1;
                            w_bl_step = r_step >> 1;
                        end
                    end
                end
            end
            default: begin
                n_wx = r_wx + CW'(r_step);
                if (n_wx >= r_side) begin
                    n_wx = '0;
                    n_wz = r_wz + CW'(r_step);
                    if (n_wz >= r_side) begin
                        w_bl = 1'b1;
                    end
                end
            end
        endcase
        // enter next level or finish the map
        if (w_bl) begin
            if (w_bl_step <= 8'd1) begin
                n_done = 1'b1;
            end else if (CW'(w_bl_step >> 1) < r_side) begin
                n_phase = dsh_pkg::PH_DIAMOND;
                n_wx = CW'(w_bl_step >> 1);
                n_wz = CW'(w_bl_step >> 1);
            end else begin
                n_phase = dsh_pkg::PH_SQUARE;
                n_wx = '0;
                n_wz = '0;
                n_edge = 1'b0;
            end
        end
        if (n_done) begin
            n_phase = dsh_pkg::PH_SEED;
            n_wx = '0;
            n_wz = '0;
            n_edge = 1'b0;
        end
    end

    // ------------------------------------------------------------ sequencer
    logic [CW-1:0] w_tx, w_tz;
    assign w_tx = r_wx + ((r_phase == dsh_pkg::PH_SQUARE && !r_edge) ? w_half : '0);
    assign w_tz = r_wz + ((r_phase == dsh_pkg::PH_SQUARE &&  r_edge) ? w_half : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_phase <= dsh_pkg::PH_SEED;
            r_wx    <= '0;
            r_wz    <= '0;
            r_edge  <= 1'b0;
            r_step  <= dsh_pkg::START_STEP_RST;
            r_noise <= dsh_pkg::NOISE_AMP_RST;
            r_side  <= CW'(MAP_SIDE_MAX);
            r_rd_v  <= 1'b0;
            r_k     <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_FIN && w_slot) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            // accumulate the read that returned this cycle
            if (r_rd_v && r_rd_in) begin
                r_sum <= r_sum + SMW'($signed(w_rdata));
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_f16 <= w_f16;
                        if (r_phase == dsh_pkg::PH_SEED && r_wx == '0 && r_wz == '0) begin
                            r_side  <= w_cfg_side;
                            r_step  <= (r_cfg_step == 8'd0) ? 8'd1 : r_cfg_step;
                            r_noise <= r_cfg_noise;
                            r_edge  <= 1'b0;
                        end
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_tx   <= w_tx;
                    r_tz   <= w_tz;
                    r_skip <= (r_phase == dsh_pkg::PH_SQUARE)
                              && !(w_tx < r_side && w_tz < r_side);
                    r_sum  <= '0;
                    r_rd_v <= 1'b0;
                    r_k    <= '0;
                    if (r_phase == dsh_pkg::PH_DIAMOND
                        || (r_phase == dsh_pkg::PH_SQUARE && w_tx < r_side && w_tz < r_side)) begin
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_RD: begin
                    r_rd_v  <= 1'b1;
                    r_rd_in <= w_inmap;
                    r_k     <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rd_v  <= 1'b0;
                    r_prod  <= PW'(r_f16 * $signed({1'b0, r_noise}));
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_slot) begin
                        r_ox    <= r_tx[7:0];
                        r_oz    <= r_tz[7:0];
                        r_oh    <= r_skip ? 24'd0 : w_sat[23:0];
                        r_ow    <= !r_skip;
                        r_od    <= n_done;
                        r_phase <= n_phase;
                        r_wx    <= n_wx;
                        r_wz    <= n_wz;
                        r_step  <= n_step;
                        r_noise <= n_noise;
                        r_edge  <= n_edge;
                        r_clr   <= '0;
                        r_state <= n_done ? S_CLR : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_cell_x    = r_ox;
    assign o_cell_z    = r_oz;
    assign o_height    = r_oh;
    assign o_wrote     = r_ow;
    assign o_map_done  = r_od;

    // ----------------------------------------------------------- assertions
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous request in progress");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_wrote) |-> (o_height == 24'd0))
        else $error("skipped edge point carries nonzero height");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request accepted before height store cleared");

endmodule

[tb/tb_diamond_square_heightmap.sv]
`timescale 1ns / 1ps
// Self-checking testbench for diamond_square_heightmap: random fractions in, cell results out.
// Depends on dsh_pkg and the block's RTL; predicts each result from its own copy of the map.
module tb_diamond_square_heightmap;

    localparam int SIDE_MAX  = 129;
    localparam int CYC_LIMIT = 2000000;

    typedef struct {
        int         side;
        int         lstep;
        int         lnoise;
        logic [1:0] phase;
        int         wx;
        int         wz;
        bit         edge_v;
    } t_walk;

    typedef struct {
        logic [7:0]         x;
        logic [7:0]         z;
        logic signed [23:0] h;
        logic               wrote;
        logic               done;
    } t_cell_res;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [15:0]        i_random_fraction = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [7:0]         o_cell_x;
    logic [7:0]         o_cell_z;
    logic signed [23:0] o_height;
    logic               o_wrote;
    logic               o_map_done;

    diamond_square_heightmap dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    int        cfg_side = 129;
    int        cfg_step = 32;
    int        cfg_noise = 256;
    t_walk     walk = '{side: 129, lstep: 32, lnoise: 256, phase: dsh_pkg::PH_SEED,
                        wx: 0, wz: 0, edge_v: 0};
    int        heights [SIDE_MAX*SIDE_MAX];
    t_cell_res cells_due [$];
    logic [15:0] fractions_pending [$];

    int  n_queued = 0;
    int  n_taken = 0;
    int  n_errors = 0;
    int  cyc = 0;
    bit  took = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  hold_req = 0;

    function automatic bit next_level(inout t_walk w);
        int half;
        if (w.lstep <= 1) return 1;
        half = w.lstep / 2;
        if (half < w.side) begin
            w.phase = dsh_pkg::PH_DIAMOND;
            w.wx = half;
            w.wz = half;
        end else begin
            w.phase = dsh_pkg::PH_SQUARE;
            w.wx = 0;
            w.wz = 0;
            w.edge_v = 0;
        end
        return 0;
    endfunction

    // Advance the walk by one request; give the target cell and the pass it belongs to.
    function automatic void walk_step(inout t_walk w, input int cs, input int cst, input int cn,
                                      output bit start, output logic [1:0] kind,
                                      output int tx, output int tz, output int half,
                                      output bit done);
        start = 0;
        done = 0;
        if (w.phase > dsh_pkg::PH_SQUARE) w.phase = dsh_pkg::PH_SEED;
        if (w.phase == dsh_pkg::PH_SEED && w.wx == 0 && w.wz == 0) begin
            start = 1;
            w.side = (cs < 1) ? 1 : (cs > SIDE_MAX) ? SIDE_MAX : cs;
            w.lstep = (cst == 0) ? 1 : cst;
            w.lnoise = cn;
            w.edge_v = 0;
        end
        half = w.lstep / 2;
        tx = w.wx;
        tz = w.wz;
        kind = w.phase;
        if (w.phase == dsh_pkg::PH_SEED) begin
            w.wx += w.lstep;
            if (w.wx >= w.side) begin
                w.wx = 0;
                w.wz += w.lstep;
                if (w.wz >= w.side) done = next_level(w);
            end
        end else if (w.phase == dsh_pkg::PH_DIAMOND) begin
            w.wx += w.lstep;
            if (w.wx >= w.side) begin
                w.wx = half;
                w.wz += w.lstep;
                if (w.wz >= w.side) begin
                    w.phase = dsh_pkg::PH_SQUARE;
                    w.wx = 0;
                    w.wz = 0;
                    w.edge_v = 0;
                end
            end
        end else begin
            if (!w.edge_v) tx += half;
            else tz += half;
            if (!w.edge_v) begin
                w.edge_v = 1;
            end else begin
                w.edge_v = 0;
                w.wx += w.lstep;
                if (w.wx >= w.side) begin
                    w.wx = 0;
                    w.wz += w.lstep;
                    if (w.wz >= w.side) begin
                        w.lstep /= 2;
                        w.lnoise >>= 1;
                        done = next_level(w);
                    end
                end
            end
        end
        if (done) begin
            w.phase = dsh_pkg::PH_SEED;
            w.wx = 0;
            w.wz = 0;
            w.edge_v = 0;
        end
    endfunction

    function automatic int map_length(int cs, int cst);
        t_walk      w;
        bit         st, dn;
        logic [1:0] k;
        int         tx, tz, hf, n;
        w = '{side: 1, lstep: 1, lnoise: 0, phase: dsh_pkg::PH_SEED, wx: 0, wz: 0, edge_v: 0};
        n = 0;
        dn = 0;
        while (!dn) begin
            walk_step(w, cs, cst, 0, st, k, tx, tz, hf, dn);
            n++;
        end
        return n;
    endfunction

    function automatic longint cell_at(int x, int z);
        if (x < 0 || z < 0 || x >= walk.side || z >= walk.side) return 0;
        return heights[x + z*walk.side];
    endfunction

    // round half up to Q12, then clamp to 24 signed bits
    function automatic longint round_sat(longint v, int s);
        longint r;
        r = (v + (longint'(1) <<< (s-1))) >>> s;
        if (r > 64'sd8388607) r = 8388607;
        if (r < -64'sd8388608) r = -8388608;
        return r;
    endfunction

    function automatic void predict_cell(logic [15:0] frac);
        bit         st, dn;
        logic [1:0] k;
        int         tx, tz, hf, ln;
        longint     f16, h, nsum;
        t_cell_res  c;
        f16 = longint'(frac) * 25 - 655360;
        // the step mixes with the noise of its own level, before any halving
        ln = walk.lnoise;
        walk_step(walk, cfg_side, cfg_step, cfg_noise, st, k, tx, tz, hf, dn);
        if (st) ln = cfg_noise;
        if (st) heights = '{default: 0};
        h = 0;
        c.wrote = 1;
        if (k == dsh_pkg::PH_SEED) begin
            h = round_sat(f16, 4);
        end else if (k == dsh_pkg::PH_DIAMOND) begin
            nsum = cell_at(tx-hf, tz-hf) + cell_at(tx+hf, tz-hf)
                 + cell_at(tx-hf, tz+hf) + cell_at(tx+hf, tz+hf);
            h = round_sat(nsum*1024 + f16*ln, 12);
        end else if (tx < walk.side && tz < walk.side) begin
            nsum = cell_at(tx-hf, tz) + cell_at(tx+hf, tz)
                 + cell_at(tx, tz-hf) + cell_at(tx, tz+hf);
            h = round_sat(nsum*1024 + f16*ln, 12);
        end else begin
            c.wrote = 0;
        end
        if (c.wrote) heights[tx + tz*walk.side] = int'(h);
        c.x = tx[7:0];
        c.z = tz[7:0];
        c.h = h[23:0];
        c.done = dn;
        cells_due.push_back(c);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (n_errors < 40)
            $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // accept requests and check results at the rising edge
    always @(posedge i_clk) begin
        t_cell_res c;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_cell(i_random_fraction);
            n_taken++;
            took = 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cells_due.size() == 0) begin
                report_mismatch("unexpected result, x", o_cell_x, -1);
            end else begin
                c = cells_due.pop_front();
                if (o_cell_x !== c.x) report_mismatch("cell_x", o_cell_x, c.x);
                if (o_cell_z !== c.z) report_mismatch("cell_z", o_cell_z, c.z);
                if (o_height !== c.h) report_mismatch("height", o_height, c.h);
                if (o_wrote !== c.wrote) report_mismatch("wrote", o_wrote, c.wrote);
                if (o_map_done !== c.done) report_mismatch("map_done", o_map_done, c.done);
            end
        end
    end

    // request driver: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (took) begin
            took = 0;
            if (burst_left > 0 && fractions_pending.size() > 0) begin
                i_random_fraction <= fractions_pending.pop_front();
                burst_left--;
            end else begin
                i_in_valid <= 0;
                burst_left = 0;
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else if (!i_in_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (fractions_pending.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                i_random_fraction <= fractions_pending.pop_front();
                i_in_valid <= 1;
                burst_left--;
            end
        end
    end

    // receiver stall pattern, with one long hold-off on request
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == dsh_pkg::CFG_MAP_SIDE) cfg_side = val[7:0];
        else if (idx == dsh_pkg::CFG_START_STEP) cfg_step = val[7:0];
        else if (idx == dsh_pkg::CFG_NOISE_AMP) cfg_noise = val;
    endtask

    function automatic logic [15:0] random_fraction();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic drain();
        while (n_taken != n_queued || cells_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_maps(int side, int stp, int noise, int maps);
        int n;
        write_reg(dsh_pkg::CFG_MAP_SIDE, 16'(side));
        write_reg(dsh_pkg::CFG_START_STEP, 16'(stp));
        write_reg(dsh_pkg::CFG_NOISE_AMP, 16'(noise));
        n = map_length(side, stp) * maps;
        for (int i = 0; i < n; i++) begin
            fractions_pending.push_back(random_fraction());
            n_queued++;
        end
        drain();
    endtask

    initial begin
        logic [15:0] corner_vals [13] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE,
                                          16'd26214, 16'd26215, 16'h5555, 16'hAAAA, 16'hFFFF,
                                          16'h0000, 16'hFFFF, 16'h0000};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // smallest real map, fraction extremes, zero noise
        write_reg(dsh_pkg::CFG_MAP_SIDE, 16'd3);
        write_reg(dsh_pkg::CFG_START_STEP, 16'd2);
        write_reg(dsh_pkg::CFG_NOISE_AMP, 16'd0);
        foreach (corner_vals[i]) begin
            fractions_pending.push_back(corner_vals[i]);
            n_queued++;
        end
        drain();

        run_maps(0, 0, 65535, 2);       // side and step both below range
        run_maps(3, 1, 100, 1);         // seed grid only
        run_maps(5, 128, 65535, 1);     // skipped diamond passes, skipped edges
        run_maps(17, 16, 65535, 1);     // saturation
        run_maps(10, 4, $urandom_range(0, 65535), 1);

        // long receiver hold-off partway through the big map
        write_reg(dsh_pkg::CFG_MAP_SIDE, 16'd25);
        write_reg(dsh_pkg::CFG_START_STEP, 16'd8);
        write_reg(dsh_pkg::CFG_NOISE_AMP, 16'($urandom_range(0, 4096)));
        for (int i = 0; i < map_length(25, 8); i++) begin
            fractions_pending.push_back(random_fraction());
            n_queued++;
        end
        while (n_taken < n_queued - 400) @(posedge i_clk);
        @(negedge i_clk);
        hold_req = 1;
        drain();

        // widest side, clamped, left unfinished
        write_reg(dsh_pkg::CFG_MAP_SIDE, 16'd255);
        write_reg(dsh_pkg::CFG_START_STEP, 16'd128);
        write_reg(dsh_pkg::CFG_NOISE_AMP, 16'hFFFF);
        for (int i = 0; i < 150; i++) begin
            fractions_pending.push_back(random_fraction());
            n_queued++;
        end
        drain();

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
